// File: src/assert_macros.svh
// Assertion macros shared by the ring buffer RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/brb_pkg.sv
// Shared types and constants of the multi-byte ring buffer.
// No dependencies; imported by the controller, the datapath and the top level.
package brb_pkg;

    localparam int LANES   = 8;
    localparam int LANE_IW = $clog2(LANES);
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 4;
    localparam int USED_W  = 11;
    localparam int ACT_W   = 3;

    localparam logic [ACT_W-1:0] ACT_ENQ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SKIP  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] in_byte_0;
        logic [BYTE_W-1:0] in_byte_1;
        logic [BYTE_W-1:0] in_byte_2;
        logic [BYTE_W-1:0] in_byte_3;
        logic [BYTE_W-1:0] in_byte_4;
        logic [BYTE_W-1:0] in_byte_5;
        logic [BYTE_W-1:0] in_byte_6;
        logic [BYTE_W-1:0] in_byte_7;
    } req_t;

    typedef struct packed {
        logic [LEN_W-1:0]  done_count;
        logic [USED_W-1:0] used_bytes;
        logic [BYTE_W-1:0] out_byte_0;
        logic [BYTE_W-1:0] out_byte_1;
        logic [BYTE_W-1:0] out_byte_2;
        logic [BYTE_W-1:0] out_byte_3;
        logic [BYTE_W-1:0] out_byte_4;
        logic [BYTE_W-1:0] out_byte_5;
        logic [BYTE_W-1:0] out_byte_6;
        logic [BYTE_W-1:0] out_byte_7;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the request
        logic clear;     // empty the buffer
        logic start;     // load the byte address and lane counter
        logic write;     // write one byte to the store
        logic read;      // read one byte from the store
        logic grow;      // commit an enqueue
        logic advance;   // remove bytes from the front
        logic set_done;  // report the request length as moved
        logic load_out;  // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
        logic enq_ok;
        logic rd_ok;
        logic skip_ok;
        logic is_deq;
        logic last;
        logic out_free;
    } status_t;

endpackage

// File: src/brb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/brb_ctrl.sv
// Sequencing state machine of the ring buffer.
// Depends on brb_pkg for the command and status structs.
module brb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  brb_pkg::status_t status,
    output brb_pkg::cmd_t    cmd
);

    import brb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_RTAIL = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (status.is_clear) begin
                    cmd.clear  = 1'b1;
                    state_next = S_RESP;
                end else if (status.enq_ok) begin
                    cmd.start  = 1'b1;
                    state_next = S_WRITE;
                end else if (status.rd_ok) begin
                    cmd.start  = 1'b1;
                    state_next = S_READ;
                end else if (status.skip_ok) begin
                    cmd.advance  = 1'b1;
                    cmd.set_done = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_WRITE: begin
                cmd.write = 1'b1;
                if (status.last) begin
                    cmd.grow     = 1'b1;
                    cmd.set_done = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_READ: begin
                cmd.read = 1'b1;
                if (status.last) begin
                    state_next = S_RTAIL;
                end
            end
            S_RTAIL: begin
                // The last byte lands in its lane at the end of this cycle.
                cmd.set_done = 1'b1;
                cmd.advance  = status.is_deq;
                state_next   = S_RESP;
            end
            S_RESP: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/brb_dp.sv
// Datapath of the ring buffer: pointers, fill count, lanes, byte store, output register.
// Depends on brb_pkg, brb_ram and assert_macros.svh.
`include "assert_macros.svh"

module brb_dp #(
    parameter int DEPTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  brb_pkg::req_t    s_payload,
    input  brb_pkg::cmd_t    cmd,
    output brb_pkg::status_t status,
    output logic             m_valid,
    input  logic             m_ready,
    output brb_pkg::rsp_t    m_payload
);

    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = AW + 5;
    localparam logic [SW-1:0]     DEPTH_S = SW'(DEPTH);
    localparam logic [FW+3:0]     DEPTH_C = (FW + 4)'(DEPTH);
    localparam logic [FW-1:0]     DEPTH_F = FW'(DEPTH);

    // Request held for the duration of the transaction.
    logic [ACT_W-1:0]  act_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] in_lane_reg [LANES];

    // Buffer state.
    logic [AW-1:0] head_reg;
    logic [AW-1:0] tail_reg;
    logic [FW-1:0] fill_reg;

    // Byte walk.
    logic [AW-1:0]      addr_reg;
    logic [LANE_IW-1:0] cnt_reg;
    logic               rd_pend_reg;
    logic [LANE_IW-1:0] rd_lane_reg;

    // Result being built, and the output register.
    logic [BYTE_W-1:0] out_lane_reg [LANES];
    logic [LEN_W-1:0]  done_reg;
    logic              m_valid_reg;
    rsp_t              m_data_reg;

    logic              len_ok;
    logic [FW+3:0]     fill_plus;
    logic [SW-1:0]     head_sum;
    logic [SW-1:0]     tail_sum;
    logic [AW-1:0]     head_adv;
    logic [AW-1:0]     tail_adv;
    logic [AW:0]       addr_sum;
    logic [AW-1:0]     addr_inc;
    logic [FW+3:0]     fill_grow;
    logic [FW+3:0]     fill_shrink;
    logic [FW+USED_W-1:0] used_wide;
    logic [BYTE_W-1:0] rdata;

    assign len_ok    = (len_reg != '0) && (len_reg <= LEN_W'(LANES));
    assign fill_plus = {4'b0, fill_reg} + {{FW{1'b0}}, len_reg};

    always_comb begin
        status          = '0;
        status.is_clear = (act_reg == ACT_CLEAR);
        status.enq_ok   = (act_reg == ACT_ENQ) && len_ok && (fill_plus <= DEPTH_C);
        status.rd_ok    = ((act_reg == ACT_DEQ) || (act_reg == ACT_PEEK)) && len_ok &&
                          ({{FW{1'b0}}, len_reg} <= {4'b0, fill_reg});
        status.skip_ok  = (act_reg == ACT_SKIP) && len_ok &&
                          ({{FW{1'b0}}, len_reg} <= {4'b0, fill_reg});
        status.is_deq   = (act_reg == ACT_DEQ);
        status.last     = (LEN_W'(cnt_reg) + LEN_W'(1)) == len_reg;
        status.out_free = !m_valid_reg || m_ready;
    end

    // Index arithmetic wraps by one compare and subtract; a committed length
    // never exceeds the buffer size.
    assign head_sum = {5'b0, head_reg} + {{(AW + 1){1'b0}}, len_reg};
    assign tail_sum = {5'b0, tail_reg} + {{(AW + 1){1'b0}}, len_reg};
    assign head_adv = (head_sum >= DEPTH_S) ? AW'(head_sum - DEPTH_S) : head_sum[AW-1:0];
    assign tail_adv = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : tail_sum[AW-1:0];
    assign addr_sum = {1'b0, addr_reg} + (AW + 1)'(1);
    assign addr_inc = (addr_sum == (AW + 1)'(DEPTH)) ? '0 : addr_sum[AW-1:0];

    assign fill_grow   = fill_plus;
    assign fill_shrink = {4'b0, fill_reg} - {{FW{1'b0}}, len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                head_reg <= '0;
                tail_reg <= '0;
                fill_reg <= '0;
            end
            if (cmd.grow) begin
                tail_reg <= tail_adv;
                fill_reg <= fill_grow[FW-1:0];
            end
            if (cmd.advance) begin
                head_reg <= head_adv;
                fill_reg <= fill_shrink[FW-1:0];
            end
            rd_pend_reg <= cmd.read;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            act_reg        <= s_payload.action;
            len_reg        <= s_payload.length;
            in_lane_reg[0] <= s_payload.in_byte_0;
            in_lane_reg[1] <= s_payload.in_byte_1;
            in_lane_reg[2] <= s_payload.in_byte_2;
            in_lane_reg[3] <= s_payload.in_byte_3;
            in_lane_reg[4] <= s_payload.in_byte_4;
            in_lane_reg[5] <= s_payload.in_byte_5;
            in_lane_reg[6] <= s_payload.in_byte_6;
            in_lane_reg[7] <= s_payload.in_byte_7;
            done_reg       <= '0;
            for (int i = 0; i < LANES; i++) begin
                out_lane_reg[i] <= '0;
            end
        end
        if (cmd.set_done) begin
            done_reg <= len_reg;
        end
        if (cmd.start) begin
            addr_reg <= (act_reg == ACT_ENQ) ? tail_reg : head_reg;
            cnt_reg  <= '0;
        end else if (cmd.write || cmd.read) begin
            addr_reg <= addr_inc;
            cnt_reg  <= cnt_reg + LANE_IW'(1);
        end
        if (cmd.read) begin
            rd_lane_reg <= cnt_reg;
        end
        if (rd_pend_reg) begin
            out_lane_reg[rd_lane_reg] <= rdata;
        end
        if (cmd.load_out) begin
            m_data_reg.done_count <= done_reg;
            m_data_reg.used_bytes <= used_wide[USED_W-1:0];
            m_data_reg.out_byte_0 <= out_lane_reg[0];
            m_data_reg.out_byte_1 <= out_lane_reg[1];
            m_data_reg.out_byte_2 <= out_lane_reg[2];
            m_data_reg.out_byte_3 <= out_lane_reg[3];
            m_data_reg.out_byte_4 <= out_lane_reg[4];
            m_data_reg.out_byte_5 <= out_lane_reg[5];
            m_data_reg.out_byte_6 <= out_lane_reg[6];
            m_data_reg.out_byte_7 <= out_lane_reg[7];
        end
    end

    assign used_wide = {{USED_W{1'b0}}, fill_reg};

    brb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.write),
        .waddr (addr_reg),
        .wdata (in_lane_reg[cnt_reg]),
        .re    (cmd.read),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    `ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg <= DEPTH_F,
        "fill count exceeds buffer depth")
    `ASSERT_ALWAYS(a_ptr_fill, aclk, aresetn,
        (head_reg == tail_reg) == ((fill_reg == '0) || (fill_reg == DEPTH_F)),
        "pointers disagree with fill count")
    `ASSERT_IMPLIES(a_load_free, aclk, aresetn, cmd.load_out, status.out_free,
        "result loaded over an untaken result")

endmodule

// File: src/byte_ring_buffer_multibyte.sv
// Top level of the multi-byte circular byte FIFO.
// Depends on brb_pkg, brb_ctrl and brb_dp (which holds the brb_ram byte store).
//
//   Channel   Ports                         Moves
//   input     s_valid, s_ready, s_payload   one request (action, length, up to 8 bytes)
//   result    m_valid, m_ready, m_payload   one result (count, fill, up to 8 bytes)
//
// One transaction is in work at a time. The byte store has a write port and a
// read port, uses one of them at a time and moves one byte per cycle; skip,
// clear and refused requests move no bytes through it. Reset is synchronous
// and active low; it empties the buffer but leaves the store contents, which
// are never read before being written. A stalled result channel holds the
// finished result in the output register; the next request is accepted
// meanwhile and waits for that register before its own result is loaded.
module byte_ring_buffer_multibyte #(
    parameter int DEPTH = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  brb_pkg::req_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output brb_pkg::rsp_t  m_payload
);

    import brb_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller sequences each transaction: evaluate, walk the bytes
    // through the store, commit pointers, then hand off the result.
    brb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the request, the pointers, the fill count, the byte
    // store and the output register.
    brb_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the multi-byte circular byte FIFO.
// Depends on brb_pkg and byte_ring_buffer_multibyte; mirrors the ring in a local model.
`timescale 1ns / 100ps

module tb_top;
    import brb_pkg::*;

    localparam int RING_DEPTH = 1024;
    localparam int CLK_HALF   = 2;

    // The DUT handles one transaction at a time through its byte store.
    // This bound covers the slowest legal run many times over.
    localparam longint RUN_LIMIT_NS = 2_000_000;

    logic  aclk      = 1'b0;
    logic  aresetn   = 1'b0;
    logic  s_valid   = 1'b0;
    logic  s_ready;
    req_t  s_payload = '0;
    logic  m_valid;
    logic  m_ready   = 1'b0;
    rsp_t  m_payload;

    // Local copy of the ring: byte slots, front and rear index, bytes held.
    logic [BYTE_W-1:0] mirror_mem [RING_DEPTH];
    int unsigned       front_ptr  = 0;
    int unsigned       rear_ptr   = 0;
    int unsigned       held_count = 0;

    // Results predicted at acceptance, oldest first.
    rsp_t awaited_results [$];

    // Idle bursts on either channel; both are switched off for the last part.
    bit gap_on   = 1'b1;
    bit stall_on = 1'b1;

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned requests_sent  = 0;
    int unsigned refused_count  = 0;
    int unsigned peak_fill      = 0;

    byte_ring_buffer_multibyte #(
        .DEPTH(RING_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #CLK_HALF aclk = ~aclk;

    // Applies one request to the local ring and returns the result the DUT
    // owes for it. Clear empties the ring whatever the length says; every
    // other request with a zero or oversize length, an unused action code,
    // or too little room or data leaves the ring alone and reports a zero count.
    // Output lanes that were not read stay zero.
    function automatic rsp_t apply_request(req_t r);
        rsp_t                     res;
        logic [LANES*BYTE_W-1:0]  lanes_in;
        logic [LANES*BYTE_W-1:0]  lanes_out;
        int unsigned              n;
        lanes_in  = r[LANES*BYTE_W-1:0];
        lanes_out = '0;
        n         = 32'(r.length);
        res       = '0;
        if (r.action == ACT_CLEAR) begin
            held_count = 0;
            front_ptr  = 0;
            rear_ptr   = 0;
        end else if (n != 0 && n <= LANES) begin
            if (r.action == ACT_ENQ) begin
                if (n <= RING_DEPTH - held_count) begin
                    for (int k = 0; k < n; k++) begin
                        mirror_mem[(rear_ptr + k) % RING_DEPTH] =
                            lanes_in[(LANES-1-k)*BYTE_W +: BYTE_W];
                    end
                    rear_ptr        = (rear_ptr + n) % RING_DEPTH;
                    held_count      = held_count + n;
                    res.done_count  = LEN_W'(n);
                end
            end else if (r.action == ACT_DEQ || r.action == ACT_PEEK ||
                         r.action == ACT_SKIP) begin
                if (n <= held_count) begin
                    if (r.action != ACT_SKIP) begin
                        for (int k = 0; k < n; k++) begin
                            lanes_out[(LANES-1-k)*BYTE_W +: BYTE_W] =
                                mirror_mem[(front_ptr + k) % RING_DEPTH];
                        end
                    end
                    if (r.action != ACT_PEEK) begin
                        front_ptr  = (front_ptr + n) % RING_DEPTH;
                        held_count = held_count - n;
                    end
                    res.done_count = LEN_W'(n);
                end
            end
        end
        res.used_bytes             = USED_W'(held_count);
        res[LANES*BYTE_W-1:0]      = lanes_out;
        return res;
    endfunction

    function automatic req_t make_request(logic [ACT_W-1:0] act, logic [LEN_W-1:0] len,
                                          logic [LANES*BYTE_W-1:0] lanes);
        req_t r;
        r                     = '0;
        r.action              = act;
        r.length              = len;
        r[LANES*BYTE_W-1:0]   = lanes;
        return r;
    endfunction

    // Draws one random request. Most are well formed and sized to what the
    // ring can take, with a drift toward full or toward empty so that the
    // fill level sweeps its whole range and the indices wrap many times.
    // The rest is noise: random codes and lengths, unused codes among them, and clears.
    function automatic req_t draw_request(bit filling);
        req_t        r;
        int unsigned pick;
        int unsigned n;
        int unsigned room;
        int unsigned code;
        r                   = '0;
        r[LANES*BYTE_W-1:0] = {$urandom, $urandom};
        pick                = $urandom_range(0, 99);
        room                = RING_DEPTH - held_count;
        n                   = $urandom_range(1, LANES);
        if (pick < 6) begin
            // Any code except clear, so noise does not undo the fill drift.
            code = $urandom_range(0, 6);
            if (code >= ACT_CLEAR) code++;
            r.action = ACT_W'(code);
            r.length = LEN_W'($urandom_range(0, 15));
        end else if (!filling && pick < 8) begin
            r.action = ACT_CLEAR;
            r.length = LEN_W'($urandom_range(0, 15));
        end else if (pick < 16) begin
            if (held_count > 0 && n > held_count) n = held_count;
            r.action = ACT_PEEK;
            r.length = LEN_W'(n);
        end else if (pick < (filling ? 72 : 38)) begin
            if (room > 0 && n > room) n = room;
            r.action = ACT_ENQ;
            r.length = LEN_W'(n);
        end else begin
            if (held_count > 0 && n > held_count) n = held_count;
            r.action = ($urandom_range(0, 9) < 7) ? ACT_DEQ : ACT_SKIP;
            r.length = LEN_W'(n);
        end
        return r;
    endfunction

    // Sends one request and predicts its result at the edge where it is
    // accepted. Valid is left high afterwards; the next call either loads
    // its payload straight away or drops valid for an idle burst first.
    task automatic push_request(input req_t r);
        rsp_t pred;
        if (gap_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = apply_request(r);
        awaited_results.push_back(pred);
        requests_sent++;
        if (pred.done_count == 0) refused_count++;
        if (held_count > peak_fill) peak_fill = held_count;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("MISMATCH result %0d: %s expected %0h got %0h", results_seen, what, want, got);
        mismatch_count++;
    endtask

    // Edge cases on a small fill: refusals on an empty ring, zero and
    // oversize lengths, unused action codes, clear with odd lengths, and
    // data bytes at both extremes.
    task automatic test_directed_edges();
        push_request(make_request(ACT_DEQ,  1, {$urandom, $urandom}));
        push_request(make_request(ACT_PEEK, 8, {$urandom, $urandom}));
        push_request(make_request(ACT_SKIP, 1, {$urandom, $urandom}));
        push_request(make_request(ACT_ENQ,  0, {$urandom, $urandom}));
        push_request(make_request(ACT_ENQ,  9, {$urandom, $urandom}));
        push_request(make_request(ACT_ENQ, 15, '1));
        push_request(make_request(ACT_ENQ,  8, '1));
        push_request(make_request(ACT_ENQ,  8, '0));
        push_request(make_request(ACT_ENQ,  1, {$urandom, $urandom}));
        push_request(make_request(ACT_PEEK, 8, '0));
        push_request(make_request(ACT_DEQ,  0, {$urandom, $urandom}));
        push_request(make_request(ACT_DEQ,  9, {$urandom, $urandom}));
        push_request(make_request(ACT_DEQ,  8, {$urandom, $urandom}));
        push_request(make_request(ACT_SKIP, 4, {$urandom, $urandom}));
        push_request(make_request(ACT_PEEK, 6, {$urandom, $urandom}));
        push_request(make_request(ACT_PEEK, 5, {$urandom, $urandom}));
        push_request(make_request(3'd5, 3,  '1));
        push_request(make_request(3'd6, 8,  '1));
        push_request(make_request(3'd7, 15, '1));
        push_request(make_request(ACT_CLEAR, 0, '1));
        push_request(make_request(ACT_ENQ,   3, {$urandom, $urandom}));
        push_request(make_request(ACT_CLEAR, 15, {$urandom, $urandom}));
        push_request(make_request(ACT_DEQ,   1, {$urandom, $urandom}));
        push_request(make_request(ACT_ENQ,   8, {8{8'hA5}}));
        push_request(make_request(ACT_DEQ,   8, '0));
    endtask

    // Fills the ring to the last byte from an offset start, so a write can
    // wrap in the middle of a transaction, then checks refusal when full
    // and reads everything back out.
    task automatic test_fill_to_full_and_wrap();
        int unsigned n;
        push_request(make_request(ACT_ENQ,  5, {$urandom, $urandom}));
        push_request(make_request(ACT_SKIP, 5, {$urandom, $urandom}));
        while (held_count < RING_DEPTH) begin
            n = $urandom_range(1, LANES);
            if (n > RING_DEPTH - held_count) n = RING_DEPTH - held_count;
            push_request(make_request(ACT_ENQ, LEN_W'(n), {$urandom, $urandom}));
        end
        push_request(make_request(ACT_ENQ,  1,             {$urandom, $urandom}));
        push_request(make_request(ACT_PEEK, LEN_W'(LANES), {$urandom, $urandom}));
        push_request(make_request(ACT_SKIP, 3,             {$urandom, $urandom}));
        push_request(make_request(ACT_ENQ,  4,             {$urandom, $urandom}));
        push_request(make_request(ACT_ENQ,  3,             {$urandom, $urandom}));
        // Near the bottom some reads ask for more than is held and get refused.
        while (held_count > 0) begin
            n = $urandom_range(1, LANES);
            push_request(make_request(($urandom_range(0, 3) != 0) ? ACT_DEQ : ACT_SKIP,
                                      LEN_W'(n), {$urandom, $urandom}));
        end
    endtask

    task automatic test_random_traffic(input int unsigned count);
        bit filling;
        filling = 1'b1;
        repeat (count) begin
            if (held_count >= RING_DEPTH - 2) filling = 1'b0;
            else if (held_count <= 2) filling = 1'b1;
            push_request(draw_request(filling));
        end
    endtask

    // Back-to-back traffic with both channels always willing.
    task automatic test_steady_stream();
        gap_on   = 1'b0;
        stall_on = 1'b0;
        test_random_traffic(250);
    endtask

    // Result side: ready drops for idle bursts between runs of readiness,
    // until the last part of the run.
    initial begin
        wait (aresetn);
        forever begin
            if (stall_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Every result transaction is compared, field by field, with the oldest
    // prediction.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, 16'(m_payload.done_count));
            end else begin
                want = awaited_results.pop_front();
                if (m_payload.done_count !== want.done_count)
                    report_mismatch("done_count", 16'(want.done_count),
                                    16'(m_payload.done_count));
                if (m_payload.used_bytes !== want.used_bytes)
                    report_mismatch("used_bytes", 16'(want.used_bytes),
                                    16'(m_payload.used_bytes));
                for (int k = 0; k < LANES; k++) begin
                    if (m_payload[(LANES-1-k)*BYTE_W +: BYTE_W] !==
                        want[(LANES-1-k)*BYTE_W +: BYTE_W])
                        report_mismatch($sformatf("out_byte_%0d", k),
                                        16'(want[(LANES-1-k)*BYTE_W +: BYTE_W]),
                                        16'(m_payload[(LANES-1-k)*BYTE_W +: BYTE_W]));
                end
            end
            results_seen++;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_fill_to_full_and_wrap();
        test_random_traffic(700);
        test_steady_stream();

        // Stop sending, let every predicted result come back, then keep
        // watching the DUT in case anything stray follows.
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Sent %0d requests, %0d of them refused or ignored; %0d results checked.",
                 requests_sent, refused_count, results_seen);
        $display("Fill level reached %0d of %0d bytes, with wraps, clears and idle bursts.",
                 peak_fill, RING_DEPTH);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("byte_ring_buffer_multibyte test passed");
        end else begin
            $display("byte_ring_buffer_multibyte test failed");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("Run limit reached with %0d results outstanding.", awaited_results.size());
        $display("byte_ring_buffer_multibyte test failed");
        $finish;
    end

endmodule
